// ===== rtl/mme_pkg.sv =====
package mme_pkg;

   localparam int MAX_DIM  = 8;
   localparam int DIM_W    = $clog2(MAX_DIM);
   localparam int ADDR_W   = 2 * DIM_W;
   localparam int DEPTH    = MAX_DIM * MAX_DIM;
   localparam int CFG_W    = 4;
   localparam int ELEM_W   = 16;
   localparam int PROD_W   = 2 * ELEM_W;
   localparam int SUM_W    = 35;
   localparam int CSR_IDX_W = 1;

   localparam logic [1:0] KIND_LOAD_A = 2'd0;
   localparam logic [1:0] KIND_LOAD_B = 2'd1;
   localparam logic [1:0] KIND_START  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_OUT_DIM   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_LEN = 1'd1;

   localparam logic [CFG_W-1:0] MAX_DIM_CFG = CFG_W'(MAX_DIM);

   // control tag that travels with each multiply-accumulate down the pipe
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last;
      logic             zero;
      logic             done;
      logic [DIM_W-1:0] row;
      logic [DIM_W-1:0] col;
   } tag_type;

   function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] reg_val);
      eff_dim = (reg_val > MAX_DIM_CFG) ? MAX_DIM_CFG : reg_val;
   endfunction

endpackage

// ===== rtl/mme_ram.sv =====
module mme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/matrix_multiply_engine_core.sv =====
// Throughput: one multiply-accumulate per cycle through the shared multiplier; a start
//   word holds busy until its last result is shown on rsp_strobe; a load never raises busy.
// The receiver cannot stall: each result is shown for exactly one cycle on rsp_strobe.
// Reset (synchronous, active high) clears the sequencer and sets both dimensions to 8;
//   the element stores are not cleared and hold nothing defined until written.
module matrix_multiply_engine_core
   import mme_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // input channel
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_kind,
   input  logic [DIM_W-1:0]        req_row,
   input  logic [DIM_W-1:0]        req_col,
   input  logic signed [ELEM_W-1:0] req_value,
   // result channel
   output logic                    rsp_strobe,
   output logic [DIM_W-1:0]        rsp_out_row,
   output logic [DIM_W-1:0]        rsp_out_col,
   output logic signed [SUM_W-1:0] rsp_product_sum,
   output logic                    rsp_last,
   // configuration port
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CFG_W-1:0]        csr_wr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [CFG_W-1:0] out_dim_ff, out_dim_in;
   logic [CFG_W-1:0] inner_len_ff, inner_len_in;
   logic [CFG_W-1:0] m_eff, n_eff;

   // issue counters: i walks rows of C, j columns, k the inner dimension
   logic [DIM_W-1:0] i_ff, i_in;
   logic [DIM_W-1:0] j_ff, j_in;
   logic [DIM_W-1:0] k_ff, k_in;
   logic             k_last, j_last, i_last;

   // pipeline: tag of the read in flight, tag of the registered product
   tag_type          s1_tag_ff, s1_tag_in;
   tag_type          s2_tag_ff, s2_tag_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic signed [SUM_W-1:0]  sum;

   // result register
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [DIM_W-1:0]        rsp_row_ff, rsp_row_in;
   logic [DIM_W-1:0]        rsp_col_ff, rsp_col_in;
   logic signed [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic                    rsp_last_ff, rsp_last_in;

   // element stores
   logic              accept;
   logic              wr_a, wr_b;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
   logic [ELEM_W-1:0] rd_data_a, rd_data_b;

   assign accept  = start && (state_ff == ST_IDLE);
   // row and column cover the whole store, so every load index is in range
   assign wr_addr = {req_row, req_col};
   assign wr_a    = accept && (req_kind == KIND_LOAD_A);
   assign wr_b    = accept && (req_kind == KIND_LOAD_B);
   assign rd_addr_a = {i_ff, k_ff};
   assign rd_addr_b = {k_ff, j_ff};

   mme_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DEPTH)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   mme_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DEPTH)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

   assign m_eff = eff_dim(out_dim_ff);
   assign n_eff = eff_dim(inner_len_ff);

   // an empty inner dimension still issues one slot per element, with the product forced to zero
   assign k_last = (n_eff == '0) || ({1'b0, k_ff} == (n_eff - CFG_W'(1)));
   assign j_last = ({1'b0, j_ff} == (m_eff - CFG_W'(1)));
   assign i_last = ({1'b0, i_ff} == (m_eff - CFG_W'(1)));

   assign sum = (s2_tag_ff.first ? SUM_W'(0) : acc_ff) + SUM_W'(prod_ff);

   always_comb begin
      state_in      = state_ff;
      out_dim_in    = out_dim_ff;
      inner_len_in  = inner_len_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      s1_tag_in     = '0;
      rsp_strobe_in = 1'b0;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_last_in   = rsp_last_ff;
      acc_in        = acc_ff;

      // take a register write as it comes; the host writes only while idle (the block does not enforce this)
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_OUT_DIM:   out_dim_in   = csr_wr_data;
            REG_INNER_LEN: inner_len_in = csr_wr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            // a start with no rows emits nothing and leaves the block idle
            if (accept && (req_kind == KIND_START) && (m_eff != '0)) begin
               state_in = ST_ISSUE;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
            end
         end
         ST_ISSUE: begin
            s1_tag_in.valid = 1'b1;
            s1_tag_in.first = (k_ff == '0);
            s1_tag_in.last  = k_last;
            s1_tag_in.zero  = (n_eff == '0);
            s1_tag_in.done  = k_last && j_last && i_last;
            s1_tag_in.row   = i_ff;
            s1_tag_in.col   = j_ff;
            if (k_last) begin
               k_in = '0;
               if (j_last) begin
                  j_in = '0;
                  if (i_last) begin
                     state_in = ST_DRAIN;
                  end else begin
                     i_in = i_ff + DIM_W'(1);
                  end
               end else begin
                  j_in = j_ff + DIM_W'(1);
               end
            end else begin
               k_in = k_ff + DIM_W'(1);
            end
         end
         ST_DRAIN: begin
            if (s2_tag_ff.valid && s2_tag_ff.done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // multiply stage: store data arrives in the cycle after the address
      s2_tag_in = s1_tag_ff;
      prod_in   = s1_tag_ff.zero ? PROD_W'(0)
                                 : $signed(rd_data_a) * $signed(rd_data_b);

      // accumulate stage: restart on the first product, emit on the last
      if (s2_tag_ff.valid) begin
         acc_in = sum;
         if (s2_tag_ff.last) begin
            rsp_strobe_in = 1'b1;
            rsp_row_in    = s2_tag_ff.row;
            rsp_col_in    = s2_tag_ff.col;
            rsp_sum_in    = sum;
            rsp_last_in   = s2_tag_ff.done;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         out_dim_ff      <= MAX_DIM_CFG;
         inner_len_ff    <= MAX_DIM_CFG;
         s1_tag_ff.valid <= 1'b0;
         s2_tag_ff.valid <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         out_dim_ff      <= out_dim_in;
         inner_len_ff    <= inner_len_in;
         s1_tag_ff.valid <= s1_tag_in.valid;
         s2_tag_ff.valid <= s2_tag_in.valid;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
      // payload: no reset needed
      i_ff            <= i_in;
      j_ff            <= j_in;
      k_ff            <= k_in;
      s1_tag_ff.first <= s1_tag_in.first;
      s1_tag_ff.last  <= s1_tag_in.last;
      s1_tag_ff.zero  <= s1_tag_in.zero;
      s1_tag_ff.done  <= s1_tag_in.done;
      s1_tag_ff.row   <= s1_tag_in.row;
      s1_tag_ff.col   <= s1_tag_in.col;
      s2_tag_ff.first <= s2_tag_in.first;
      s2_tag_ff.last  <= s2_tag_in.last;
      s2_tag_ff.zero  <= s2_tag_in.zero;
      s2_tag_ff.done  <= s2_tag_in.done;
      s2_tag_ff.row   <= s2_tag_in.row;
      s2_tag_ff.col   <= s2_tag_in.col;
      prod_ff         <= prod_in;
      acc_ff          <= acc_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_sum_ff      <= rsp_sum_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_product_sum = rsp_sum_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
